### design/atab_pkg.sv
// ----------------------------------------------------------------------------
// atab_pkg
// shared constants and helpers for the argb tint and alpha blend core
// ----------------------------------------------------------------------------
package atab_pkg;

    localparam int unsigned PIXEL_W    = 32;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned PROD_W     = 2 * CHAN_W;
    localparam int unsigned COLOR_CHANS = 3;
    localparam int unsigned ALL_CHANS  = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'hFF;
    localparam logic [PIXEL_W-1:0] TINT_RESET = 32'hFFFF_FFFF;

    // register indexes, byte address is 4 * index
    typedef enum logic [0:0] {
        REG_TINT_COLOR = 1'b0
    } reg_idx_t;

    // floor(x / 255) for any product of two 8-bit channels
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + {{PROD_W{1'b0}}, 1'b1} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]};
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

### design/argb_tint_and_alpha_blend_core.sv
// ----------------------------------------------------------------------------
// argb_tint_and_alpha_blend_core
// argb8888 source tint followed by source-over blend onto an opaque dest
// ----------------------------------------------------------------------------
// an accepted input word is registered in s1, s2, s3 and then the output register, which drives out_valid
// throughput: one pixel per clock while out_stall is low; four stages (tint multiply,
// tint divide, blend multiply, blend divide and sum) each with a valid bit
// a stall on the output backs up only through occupied stages
// reset clears all valid bits and sets tint_color to all ones
module argb_tint_and_alpha_blend_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [atab_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [atab_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [atab_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [atab_pkg::PIXEL_W-1:0]      src_pixel,
    input  logic [atab_pkg::PIXEL_W-1:0]      dest_pixel,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [atab_pkg::PIXEL_W-1:0]      result_pixel
);
    import atab_pkg::*;

    localparam int unsigned COLOR_W = COLOR_CHANS * CHAN_W;

    // configuration
    logic [PIXEL_W-1:0] tint_reg;
    logic [PIXEL_W-1:0] tint_next;
    logic               reg_sel;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = (reg_idx_t'(paddr[APB_ADDR_W-1]) == REG_TINT_COLOR);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

    always_comb
    begin
        tint_next = tint_reg;
        if (cfg_wr)
        begin
            tint_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_reg <= TINT_RESET;
        end
        else
        begin
            tint_reg <= tint_next;
        end
    end

    assign prdata = reg_sel ? tint_reg : '0;

    // pipeline registers
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [PROD_W-1:0]  s1_prod_reg  [ALL_CHANS];
    logic [PROD_W-1:0]  s1_prod_next [ALL_CHANS];
    logic [COLOR_W-1:0] s1_dest_reg;
    logic [PIXEL_W-1:0] s2_tint_px_reg;
    logic [PIXEL_W-1:0] s2_tint_px_next;
    logic [COLOR_W-1:0] s2_dest_reg;
    logic [PIXEL_W-1:0] s3_tint_px_reg;
    logic               s3_opaque_reg;
    logic               s3_opaque_next;
    logic [PROD_W-1:0]  s3_sa_reg  [COLOR_CHANS];
    logic [PROD_W-1:0]  s3_sa_next [COLOR_CHANS];
    logic [PROD_W-1:0]  s3_da_reg  [COLOR_CHANS];
    logic [PROD_W-1:0]  s3_da_next [COLOR_CHANS];
    logic [PIXEL_W-1:0] result_reg;
    logic [PIXEL_W-1:0] result_next;
    logic [CHAN_W-1:0]  s2_alpha;
    logic [CHAN_W-1:0]  s2_inv_alpha;

    // stage advance, each stage moves when it is empty or its successor moves
    logic adv_out, adv3, adv2, adv1;

    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv3     = !s3_valid_reg || adv_out;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage datapath
    always_comb
    begin
        for (int i = 0; i < ALL_CHANS; i++)
        begin
            s1_prod_next[i] = PROD_W'(src_pixel[i*CHAN_W +: CHAN_W])
                            * PROD_W'(tint_reg[i*CHAN_W +: CHAN_W]);
        end
        for (int i = 0; i < ALL_CHANS; i++)
        begin
            s2_tint_px_next[i*CHAN_W +: CHAN_W] = div255(s1_prod_reg[i]);
        end
        s2_alpha       = s2_tint_px_reg[PIXEL_W-1 -: CHAN_W];
        s2_inv_alpha   = CHAN_MAX - s2_alpha;
        s3_opaque_next = (s2_alpha == CHAN_MAX);
        for (int i = 0; i < COLOR_CHANS; i++)
        begin
            s3_sa_next[i] = PROD_W'(s2_tint_px_reg[i*CHAN_W +: CHAN_W]) * PROD_W'(s2_alpha);
            s3_da_next[i] = PROD_W'(s2_dest_reg[i*CHAN_W +: CHAN_W]) * PROD_W'(s2_inv_alpha);
        end
        result_next[PIXEL_W-1 -: CHAN_W] = CHAN_MAX;
        for (int i = 0; i < COLOR_CHANS; i++)
        begin
            // each term is bounded by alpha and 255 - alpha, so the sum fits
            result_next[i*CHAN_W +: CHAN_W] = div255(s3_sa_reg[i]) + div255(s3_da_reg[i]);
        end
        if (s3_opaque_reg)
        begin
            result_next = s3_tint_px_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_dest_reg <= dest_pixel[COLOR_W-1:0];
        end
        if (adv2)
        begin
            s2_tint_px_reg <= s2_tint_px_next;
            s2_dest_reg    <= s1_dest_reg;
        end
        if (adv3)
        begin
            s3_tint_px_reg <= s2_tint_px_reg;
            s3_opaque_reg  <= s3_opaque_next;
            s3_sa_reg      <= s3_sa_next;
            s3_da_reg      <= s3_da_next;
        end
        if (adv_out)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_pixel = result_reg;

    // checks
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted word did not enter stage 1");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg)
        else $error("input stalled with an empty stage");

    a_result_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_pixel[PIXEL_W-1 -: CHAN_W] == CHAN_MAX)
        else $error("result alpha not opaque");

    a_out_from_s3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("output word without a stage 3 word");

endmodule
